// File: design/nll_pkg.sv
// shared types and constants for the numeric literal lexer
// character class record, lexer states, radix and token type codes
// no dependencies
package nll_pkg;

    // request queue between front and back
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // character codes
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChUnder = 8'h5f;
    localparam logic [7:0] ChComma = 8'h2c;
    localparam logic [7:0] ChDot   = 8'h2e;
    localparam logic [7:0] ChMinus = 8'h2d;
    localparam logic [7:0] Ch0     = 8'h30;
    localparam logic [7:0] Ch1     = 8'h31;
    localparam logic [7:0] Ch7     = 8'h37;
    localparam logic [7:0] Ch9     = 8'h39;
    localparam logic [7:0] ChA     = 8'h61;
    localparam logic [7:0] ChB     = 8'h62;
    localparam logic [7:0] ChE     = 8'h65;
    localparam logic [7:0] ChF     = 8'h66;
    localparam logic [7:0] ChI     = 8'h69;
    localparam logic [7:0] ChX     = 8'h78;

    // classified request handed from front to back
    typedef struct packed {
        logic eoi;
        logic space;
        logic grp;
        logic zero;
        logic bin;
        logic oct;
        logic dig;
        logic hex;
        logic b;
        logic x;
        logic dot;
        logic e;
        logic minus;
        logic i;
    } char_cls_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_U_PREFIX,
        ST_U_REQ,
        ST_U_OPT,
        ST_F_REQ,
        ST_F_OPT,
        ST_F_ESIGN,
        ST_F_EREQ,
        ST_F_EOPT,
        ST_S_SIGN,
        ST_S_REQ,
        ST_S_OPT,
        ST_STR,
        ST_INV
    } lex_state_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_BIN,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    typedef enum logic [2:0] {
        TY_INVALID  = 3'd0,
        TY_SIGNED   = 3'd1,
        TY_UNSIGNED = 3'd2,
        TY_FLOAT    = 3'd3,
        TY_STRING   = 3'd4
    } tok_type_t;

endpackage

// File: design/nll_if.sv
// valid/ready channel interfaces for the numeric literal lexer
// character input channel and token result channel; no dependencies
interface nll_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface nll_tok_if;
    logic       valid;
    logic       ready;
    logic       keep;
    logic       token_done;
    logic [2:0] token_type;
    logic       minus_accepted;

    modport source (output valid, output keep, output token_done, output token_type,
                    output minus_accepted, input ready);
    modport sink   (input valid, input keep, input token_done, input token_type,
                    input minus_accepted, output ready);
endinterface

// File: design/numeric_literal_lexer.sv
// numeric literal lexer: one result per character, one character per cycle unless the result stalls
// the accepting edge writes the queue; a later pop steps the state machine into the output
// register, which offers the result; the state update sets the rate
// a 4-entry queue lets the front keep accepting while a result waits downstream
// reset: async active low, clears state to idle, radix decimal, queue empty, no result
// depends on nll_pkg, nll_if, nll_front, nll_queue, nll_back
module numeric_literal_lexer (
    input  logic         clk,
    input  logic         rst_n,
    nll_char_if.sink     char_in,
    nll_tok_if.source    token_out
);
    import nll_pkg::*;

    logic      push, pop, q_full, q_empty;
    char_cls_t push_cls, pop_cls;

    nll_front u_front (
        .char_in  (char_in),
        .q_full   (q_full),
        .push     (push),
        .push_cls (push_cls)
    );

    nll_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cls (push_cls),
        .full     (q_full),
        .pop      (pop),
        .pop_cls  (pop_cls),
        .empty    (q_empty)
    );

    nll_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .cls     (pop_cls),
        .pop     (pop),
        .tok_out (token_out)
    );
endmodule

// File: design/nll_front.sv
// front end: accepts characters and classifies them into a class record
// depends on nll_pkg and nll_char_if
module nll_front (
    nll_char_if.sink          char_in,
    input  logic              q_full,
    output logic              push,
    output nll_pkg::char_cls_t push_cls
);
    import nll_pkg::*;

    logic [7:0] c;

    assign c            = char_in.ch;
    assign char_in.ready = !q_full;
    assign push         = char_in.valid && !q_full;

    // character classification
    always_comb
    begin
        push_cls.eoi   = char_in.end_of_input;
        push_cls.space = (c == ChSpace);
        push_cls.grp   = (c == ChUnder) || (c == ChComma);
        push_cls.zero  = (c == Ch0);
        push_cls.bin   = (c == Ch0) || (c == Ch1);
        push_cls.oct   = (c >= Ch0) && (c <= Ch7);
        push_cls.dig   = (c >= Ch0) && (c <= Ch9);
        push_cls.hex   = ((c >= Ch0) && (c <= Ch9)) || ((c >= ChA) && (c <= ChF));
        push_cls.b     = (c == ChB);
        push_cls.x     = (c == ChX);
        push_cls.dot   = (c == ChDot);
        push_cls.e     = (c == ChE);
        push_cls.minus = (c == ChMinus);
        push_cls.i     = (c == ChI);
    end
endmodule

// File: design/nll_queue.sv
// short request queue between front and back
// depends on nll_pkg
module nll_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nll_pkg::char_cls_t push_cls,
    output logic               full,
    input  logic               pop,
    output nll_pkg::char_cls_t pop_cls,
    output logic               empty
);
    import nll_pkg::*;

    char_cls_t      mem_reg [QDepth];
    logic [QAw-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAw-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAw:0]   count_reg, count_next;

    assign full    = (count_reg == (QAw+1)'(QDepth));
    assign empty   = (count_reg == '0);
    assign pop_cls = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAw'(push);
        rd_ptr_next = rd_ptr_reg + QAw'(pop);
        count_next  = count_reg + (QAw+1)'(push) - (QAw+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cls;
        end
    end
endmodule

// File: design/nll_back.sv
// back end: lexer state machine and registered token result
// depends on nll_pkg and nll_tok_if
module nll_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  nll_pkg::char_cls_t cls,
    output logic               pop,
    nll_tok_if.source          tok_out
);
    import nll_pkg::*;

    lex_state_t state_reg, state_next;
    radix_t     radix_reg, radix_next;
    logic       minus_reg, minus_next;

    logic       out_valid_reg;
    logic       keep_reg, done_reg, macc_reg;
    tok_type_t  type_reg;

    logic       keep_c, done_c;
    tok_type_t  type_c;
    logic       radix_dig;

    // type given to a token closed in a state
    function automatic tok_type_t close_type(lex_state_t s);
        tok_type_t t;
        case (s)
            ST_U_PREFIX, ST_U_OPT: t = TY_UNSIGNED;
            ST_F_OPT, ST_F_EOPT:   t = TY_FLOAT;
            ST_S_OPT:              t = TY_SIGNED;
            ST_S_SIGN, ST_STR:     t = TY_STRING;
            default:               t = TY_INVALID;
        endcase
        return t;
    endfunction

    assign pop           = !q_empty && (!out_valid_reg || tok_out.ready);
    assign tok_out.valid          = out_valid_reg;
    assign tok_out.keep           = keep_reg;
    assign tok_out.token_done     = done_reg;
    assign tok_out.token_type     = type_reg;
    assign tok_out.minus_accepted = macc_reg;

    // digit test for the current radix
    always_comb
    begin
        case (radix_reg)
            RADIX_BIN: radix_dig = cls.bin;
            RADIX_OCT: radix_dig = cls.oct;
            RADIX_HEX: radix_dig = cls.hex;
            default:   radix_dig = cls.dig;
        endcase
    end

    // next state and result
    always_comb
    begin
        state_next = state_reg;
        radix_next = radix_reg;
        minus_next = minus_reg;
        keep_c     = 1'b0;
        done_c     = 1'b0;
        type_c     = TY_INVALID;
        if (cls.eoi || (cls.space && state_reg != ST_IDLE))
        begin
            if (state_reg != ST_IDLE)
            begin
                done_c = 1'b1;
                type_c = close_type(state_reg);
            end
            state_next = ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_U_PREFIX:
                begin
                    if (!cls.grp)
                    begin
                        keep_c = 1'b1;
                        if (cls.b)
                        begin
                            radix_next = RADIX_BIN;
                            state_next = ST_U_REQ;
                        end
                        else if (cls.x)
                        begin
                            radix_next = RADIX_HEX;
                            state_next = ST_U_REQ;
                        end
                        else if (cls.oct)
                        begin
                            radix_next = RADIX_OCT;
                            state_next = ST_U_OPT;
                        end
                        else if (cls.dot)
                            state_next = ST_F_OPT;
                        else if (cls.e)
                            state_next = ST_F_ESIGN;
                        else
                        begin
                            keep_c     = 1'b0;
                            state_next = ST_INV;
                        end
                    end
                end
                ST_U_REQ, ST_U_OPT:
                begin
                    if (!cls.grp)
                    begin
                        keep_c = 1'b1;
                        if (radix_reg == RADIX_DEC && cls.dot)
                            state_next = ST_F_OPT;
                        else if (radix_reg == RADIX_DEC && cls.e)
                            state_next = ST_F_ESIGN;
                        else if (radix_dig)
                            state_next = ST_U_OPT;
                        else
                        begin
                            keep_c     = 1'b0;
                            state_next = ST_INV;
                        end
                    end
                end
                ST_F_REQ, ST_F_OPT:
                begin
                    keep_c = 1'b1;
                    if (cls.e)
                        state_next = ST_F_ESIGN;
                    else if (cls.dig)
                        state_next = ST_F_OPT;
                    else
                    begin
                        keep_c     = 1'b0;
                        state_next = ST_INV;
                    end
                end
                ST_F_ESIGN:
                begin
                    keep_c = 1'b1;
                    if (cls.minus)
                        state_next = ST_F_EREQ;
                    else if (cls.dig)
                        state_next = ST_F_EOPT;
                    else
                    begin
                        keep_c     = 1'b0;
                        state_next = ST_INV;
                    end
                end
                ST_F_EREQ:
                begin
                    if (cls.dig)
                    begin
                        keep_c     = 1'b1;
                        state_next = ST_F_EOPT;
                    end
                    else
                        state_next = ST_INV;
                end
                ST_F_EOPT:
                begin
                    if (!cls.grp)
                    begin
                        if (cls.dig)
                            keep_c = 1'b1;
                        else
                            state_next = ST_INV;
                    end
                end
                ST_S_SIGN:
                begin
                    keep_c = 1'b1;
                    if (cls.minus)
                    begin
                        minus_next = 1'b1;
                        state_next = ST_S_REQ;
                    end
                    else if (cls.dig)
                        state_next = ST_S_OPT;
                    else
                        state_next = ST_STR;
                end
                ST_S_REQ:
                begin
                    if (cls.dig)
                    begin
                        keep_c     = 1'b1;
                        state_next = ST_S_OPT;
                    end
                    else
                        state_next = ST_INV;
                end
                ST_S_OPT:
                begin
                    if (!cls.grp)
                    begin
                        if (cls.dig)
                            keep_c = 1'b1;
                        else if (minus_reg)
                            state_next = ST_INV;
                        else
                        begin
                            keep_c     = 1'b1;
                            state_next = ST_STR;
                        end
                    end
                end
                ST_STR:
                    keep_c = 1'b1;
                ST_INV:
                    keep_c = 1'b0;
                default:
                begin
                    // idle: open a token unless the character is a separator
                    radix_next = RADIX_DEC;
                    minus_next = 1'b0;
                    if (cls.space)
                        state_next = ST_IDLE;
                    else
                    begin
                        keep_c = 1'b1;
                        if (cls.zero)
                            state_next = ST_U_PREFIX;
                        else if (cls.dig)
                            state_next = ST_U_OPT;
                        else if (cls.dot)
                            state_next = ST_F_REQ;
                        else if (cls.i)
                            state_next = ST_S_SIGN;
                        else
                            state_next = ST_STR;
                    end
                end
            endcase
        end
        if (state_next == ST_IDLE)
        begin
            radix_next = RADIX_DEC;
            minus_next = 1'b0;
        end
    end

    // lexer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_DEC;
            minus_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= state_next;
                radix_reg <= radix_next;
                minus_reg <= minus_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (tok_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            keep_reg <= keep_c;
            done_reg <= done_c;
            type_reg <= type_c;
            macc_reg <= (state_next == ST_S_SIGN) || (state_next == ST_F_ESIGN);
        end
    end
endmodule

// File: design/nll_checker.sv
// port-level checks on the numeric literal lexer result channel
// depends on nll_pkg; bound to numeric_literal_lexer
module nll_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       keep,
    input logic       token_done,
    input logic [2:0] token_type,
    input logic       minus_accepted
);
    import nll_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_type)
            && $stable(token_done) && $stable(keep) && $stable(minus_accepted))
        else $error("stalled result changed");

    // type is invalid code unless a token closed
    a_type_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !token_done |-> token_type == TY_INVALID)
        else $error("token type without close");

    // closing request never keeps its character and never leaves a sign pending
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_done |-> !keep && !minus_accepted)
        else $error("close with keep or minus");

    // only defined type codes
    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_type <= TY_STRING)
        else $error("undefined token type");
endmodule

bind numeric_literal_lexer nll_checker u_nll_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (token_out.valid),
    .out_ready      (token_out.ready),
    .keep           (token_out.keep),
    .token_done     (token_out.token_done),
    .token_type     (token_out.token_type),
    .minus_accepted (token_out.minus_accepted)
);

// File: tb/nll_token_check.sv
// token result checker for the numeric literal lexer
// watches both channels, predicts one result per accepted request and compares in order
// depends on nll_pkg and nll_if
module nll_token_check (
    input  logic clk,
    input  logic rst_n,
    nll_char_if  char_mon,
    nll_tok_if   tok_mon,
    output int   fail_count,
    output int   pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import nll_pkg::*;

    typedef struct packed {
        logic      keep;
        logic      done;
        tok_type_t kind;
        logic      minus_ok;
    } lex_result_t;

    // predicted lexer state
    lex_state_t lex_state;
    radix_t     lex_radix;
    logic       lex_minus;

    lex_result_t token_expect[$];
    int          mismatches = 0;
    int          results_seen = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(string field, int got, int want_v);
        mismatches++;
        if (mismatches <= 20)
            $display("%0t ns result %0d: %s got %0d, expected %0d",
                     $time, results_seen, field, got, want_v);
    endtask

    // one lexer step: advances the predicted state and returns the expected result
    function automatic lex_result_t lex_next(logic [7:0] c, logic eoi);
        lex_state_t  ns;
        lex_result_t r;
        logic        grp;
        logic        dig;
        logic        rdig;
        ns   = lex_state;
        r    = '0;
        r.kind = TY_INVALID;
        grp  = (c == ChUnder) || (c == ChComma);
        dig  = (c >= Ch0) && (c <= Ch9);
        case (lex_radix)
            RADIX_BIN: rdig = (c == Ch0) || (c == Ch1);
            RADIX_OCT: rdig = (c >= Ch0) && (c <= Ch7);
            RADIX_HEX: rdig = dig || ((c >= ChA) && (c <= ChF));
            default:   rdig = dig;
        endcase

        if (eoi || (c == ChSpace && lex_state != ST_IDLE))
        begin
            // close the open token, if any
            if (lex_state != ST_IDLE)
            begin
                r.done = 1'b1;
                case (lex_state)
                    ST_U_PREFIX, ST_U_OPT: r.kind = TY_UNSIGNED;
                    ST_F_OPT, ST_F_EOPT:   r.kind = TY_FLOAT;
                    ST_S_OPT:              r.kind = TY_SIGNED;
                    ST_S_SIGN, ST_STR:     r.kind = TY_STRING;
                    default:               r.kind = TY_INVALID;
                endcase
            end
            ns = ST_IDLE;
        end
        else
        begin
            case (lex_state)
                ST_U_PREFIX:
                begin
                    if (!grp)
                    begin
                        r.keep = 1'b1;
                        if (c == ChB)
                        begin
                            lex_radix = RADIX_BIN;
                            ns = ST_U_REQ;
                        end
                        else if (c == ChX)
                        begin
                            lex_radix = RADIX_HEX;
                            ns = ST_U_REQ;
                        end
                        else if (c >= Ch0 && c <= Ch7)
                        begin
                            lex_radix = RADIX_OCT;
                            ns = ST_U_OPT;
                        end
                        else if (c == ChDot)
                            ns = ST_F_OPT;
                        else if (c == ChE)
                            ns = ST_F_ESIGN;
                        else
                        begin
                            r.keep = 1'b0;
                            ns = ST_INV;
                        end
                    end
                end
                ST_U_REQ, ST_U_OPT:
                begin
                    if (!grp)
                    begin
                        r.keep = 1'b1;
                        if (lex_radix == RADIX_DEC && c == ChDot)
                            ns = ST_F_OPT;
                        else if (lex_radix == RADIX_DEC && c == ChE)
                            ns = ST_F_ESIGN;
                        else if (rdig)
                            ns = ST_U_OPT;
                        else
                        begin
                            r.keep = 1'b0;
                            ns = ST_INV;
                        end
                    end
                end
                ST_F_REQ, ST_F_OPT:
                begin
                    r.keep = 1'b1;
                    if (c == ChE)
                        ns = ST_F_ESIGN;
                    else if (dig)
                        ns = ST_F_OPT;
                    else
                    begin
                        r.keep = 1'b0;
                        ns = ST_INV;
                    end
                end
                ST_F_ESIGN:
                begin
                    r.keep = 1'b1;
                    if (c == ChMinus)
                        ns = ST_F_EREQ;
                    else if (dig)
                        ns = ST_F_EOPT;
                    else
                    begin
                        r.keep = 1'b0;
                        ns = ST_INV;
                    end
                end
                ST_F_EREQ:
                begin
                    if (dig)
                    begin
                        r.keep = 1'b1;
                        ns = ST_F_EOPT;
                    end
                    else
                        ns = ST_INV;
                end
                ST_F_EOPT:
                begin
                    if (!grp)
                    begin
                        if (dig)
                            r.keep = 1'b1;
                        else
                            ns = ST_INV;
                    end
                end
                ST_S_SIGN:
                begin
                    r.keep = 1'b1;
                    if (c == ChMinus)
                    begin
                        lex_minus = 1'b1;
                        ns = ST_S_REQ;
                    end
                    else if (dig)
                        ns = ST_S_OPT;
                    else
                        ns = ST_STR;
                end
                ST_S_REQ:
                begin
                    if (dig)
                    begin
                        r.keep = 1'b1;
                        ns = ST_S_OPT;
                    end
                    else
                        ns = ST_INV;
                end
                ST_S_OPT:
                begin
                    if (!grp)
                    begin
                        if (dig)
                            r.keep = 1'b1;
                        else if (lex_minus)
                            ns = ST_INV;
                        else
                        begin
                            r.keep = 1'b1;
                            ns = ST_STR;
                        end
                    end
                end
                ST_STR:
                    r.keep = 1'b1;
                ST_INV:
                    r.keep = 1'b0;
                default:
                begin
                    // idle: a non-space character opens a token
                    lex_radix = RADIX_DEC;
                    lex_minus = 1'b0;
                    if (c != ChSpace)
                    begin
                        r.keep = 1'b1;
                        if (c == Ch0)
                            ns = ST_U_PREFIX;
                        else if (dig)
                            ns = ST_U_OPT;
                        else if (c == ChDot)
                            ns = ST_F_REQ;
                        else if (c == ChI)
                            ns = ST_S_SIGN;
                        else
                            ns = ST_STR;
                    end
                end
            endcase
        end

        if (ns == ST_IDLE)
        begin
            lex_radix = RADIX_DEC;
            lex_minus = 1'b0;
        end
        lex_state  = ns;
        r.minus_ok = (ns == ST_S_SIGN) || (ns == ST_F_ESIGN);
        return r;
    endfunction

    // compare each result with the oldest prediction, then predict the new request
    always @(posedge clk or negedge rst_n)
    begin : watch
        lex_result_t want;
        if (!rst_n)
        begin
            lex_state = ST_IDLE;
            lex_radix = RADIX_DEC;
            lex_minus = 1'b0;
            token_expect.delete();
            pending_results = 0;
        end
        else
        begin
            if (tok_mon.valid && tok_mon.ready)
            begin
                results_seen++;
                if (token_expect.size() == 0)
                    report_mismatch("result with no request pending", 1, 0);
                else
                begin
                    want = token_expect.pop_front();
                    if (tok_mon.keep !== want.keep)
                        report_mismatch("keep", int'(tok_mon.keep), int'(want.keep));
                    if (tok_mon.token_done !== want.done)
                        report_mismatch("token_done", int'(tok_mon.token_done),
                                        int'(want.done));
                    if (tok_mon.token_type !== want.kind)
                        report_mismatch("token_type", int'(tok_mon.token_type),
                                        int'(want.kind));
                    if (tok_mon.minus_accepted !== want.minus_ok)
                        report_mismatch("minus_accepted", int'(tok_mon.minus_accepted),
                                        int'(want.minus_ok));
                end
            end
            if (char_mon.valid && char_mon.ready)
                token_expect.insert(token_expect.size(),
                                    lex_next(char_mon.ch, char_mon.end_of_input));
            pending_results = token_expect.size();
        end
    end

endmodule

// File: tb/testbench.sv
// top of the numeric literal lexer testbench: clock, reset, request stimulus, verdict
// instantiates numeric_literal_lexer and nll_token_check; depends on nll_pkg and nll_if
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nll_pkg::*;

    localparam int RandomItems   = 1750;
    localparam int WatchdogLimit = 2000;
    localparam int HoldCycles    = 200;

    logic clk;
    logic rst_n;

    nll_char_if char_bus ();
    nll_tok_if  tok_bus ();

    int         fail_count;
    int         pending_results;
    bit         idle_on = 1'b1;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         chars_sent = 0;
    logic [7:0] lit_chars[$];

    numeric_literal_lexer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_bus),
        .token_out (tok_bus)
    );

    nll_token_check token_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_mon        (char_bus),
        .tok_mon         (tok_bus),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin
        tok_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                tok_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                tok_bus.ready <= !idle_on || ($urandom_range(99) >= 12);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_bus.valid && char_bus.ready) || (tok_bus.valid && tok_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
                $display("** numeric_literal_lexer: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eoi);
        while (idle_on && $urandom_range(99) < 12)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid        <= 1'b1;
        char_bus.ch           <= c;
        char_bus.end_of_input <= eoi;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], 1'b0);
    endtask

    // add one character at the end of the literal
    task automatic append_char(input logic [7:0] c);
        lit_chars.insert(lit_chars.size(), c);
    endtask

    // append random digits of a radix, optionally with grouping marks sprinkled in
    task automatic add_digits(input radix_t r, input int count, input bit grouped);
        logic [7:0] d;
        int         n;
        for (int k = 0; k < count; k++)
        begin
            case (r)
                RADIX_BIN: d = 8'(Ch0 + $urandom_range(1));
                RADIX_OCT: d = 8'(Ch0 + $urandom_range(7));
                RADIX_HEX:
                begin
                    n = $urandom_range(15);
                    d = (n < 10) ? 8'(Ch0 + n) : 8'(ChA + n - 10);
                end
                default:   d = 8'(Ch0 + $urandom_range(9));
            endcase
            append_char(d);
            if (grouped && $urandom_range(4) == 0)
                append_char($urandom_range(1) ? ChUnder : ChComma);
        end
    endtask

    // build one literal of the given flavor into lit_chars
    task automatic build_literal(input int flavor);
        lit_chars.delete();
        case (flavor)
            0: add_digits(RADIX_DEC, $urandom_range(1, 8), 1'b1);
            1:
            begin
                append_char(Ch0);
                append_char(ChX);
                add_digits(RADIX_HEX, $urandom_range(0, 6), 1'b1);
            end
            2:
            begin
                append_char(Ch0);
                append_char(ChB);
                add_digits(RADIX_BIN, $urandom_range(0, 8), 1'b1);
            end
            3:
            begin
                append_char(Ch0);
                add_digits(RADIX_OCT, $urandom_range(0, 6), 1'b1);
            end
            4:
            begin
                append_char(ChI);
                if ($urandom_range(1))
                    append_char(ChMinus);
                add_digits(RADIX_DEC, $urandom_range(0, 6), 1'b1);
                if ($urandom_range(3) == 0)
                    append_char(8'($urandom_range(8'h61, 8'h7a)));
            end
            5:
            begin
                add_digits(RADIX_DEC, $urandom_range(0, 3), 1'b0);
                if ($urandom_range(3) != 0)
                    append_char(ChDot);
                add_digits(RADIX_DEC, $urandom_range(0, 3), 1'b0);
                if ($urandom_range(1))
                begin
                    append_char(ChE);
                    if ($urandom_range(1))
                        append_char(ChMinus);
                    add_digits(RADIX_DEC, $urandom_range(0, 3), 1'b1);
                end
            end
            6:
                repeat ($urandom_range(1, 6))
                    append_char(8'($urandom_range(8'h21, 8'h7e)));
            default:
                repeat ($urandom_range(1, 6))
                    append_char(8'($urandom_range(255)));
        endcase
    endtask

    // stimulus and verdict
    initial
    begin
        int  base;
        int  flavor;
        bit  held;
        held = 1'b0;
        rst_n <= 1'b0;
        char_bus.valid        <= 1'b0;
        char_bus.ch           <= '0;
        char_bus.end_of_input <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone separator, empty end, lone zero, bare i and i-, dot only,
        // float ending in e-, byte extremes as a string, a hex literal
        send_char(ChSpace, 1'b0);
        send_char(8'($urandom_range(255)), 1'b1);
        send_text("0 i i-");
        send_char(8'h00, 1'b1);
        send_text(". 1e-");
        send_char(8'hff, 1'b1);
        send_char(8'hff, 1'b0);
        send_char(8'h00, 1'b0);
        send_text(" 0xaf9_ ");

        // random literals, mostly well formed, some noise and some corrupted
        base = chars_sent;
        while (chars_sent < base + RandomItems)
        begin
            idle_on = !((chars_sent - base >= 800) && (chars_sent - base < 1100));
            if (!held && chars_sent - base >= 300)
            begin
                held = 1'b1;
                hold_left = HoldCycles;
            end
            flavor = int'($urandom_range(9));
            build_literal(flavor > 7 ? int'($urandom_range(5)) : flavor);
            if (flavor > 7 && lit_chars.size() > 0)
                lit_chars[$urandom_range(lit_chars.size() - 1)] = 8'($urandom_range(255));
            foreach (lit_chars[k])
                send_char(lit_chars[k], 1'b0);
            if ($urandom_range(9) == 0)
                send_char(8'($urandom_range(255)), 1'b1);
            else
                repeat ($urandom_range(1, 2))
                    send_char(ChSpace, 1'b0);
        end
        char_bus.valid <= 1'b0;

        // drain outstanding results
        while (pending_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("** numeric_literal_lexer: PASSED **");
        else
            $display("** numeric_literal_lexer: FAILED **");
        $finish;
    end

endmodule
